// ----- sv/teq_pkg.sv -----
// shared types and constants of the time ordered event queue
`default_nettype none
package teq_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned SlotBits = 6;
  localparam int unsigned LinkBits = 7;
  localparam int unsigned EventTypes = 8;
  localparam int unsigned MaxOut = 64;
  localparam logic [LinkBits-1:0] Nil = LinkBits'(Capacity);

  typedef enum logic [2:0] {
    FUNC_INSERT = 3'd0,
    FUNC_EXECUTE = 3'd1,
    FUNC_RETIRE = 3'd2,
    FUNC_FIRST = 3'd3,
    FUNC_LATEST = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_DUE = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_EXE_RD,
    S_EXE_CHK,
    S_RET_RD,
    S_RET_CHK,
    S_FIRST_RD,
    S_FIRST_CHK,
    S_LAT_RD,
    S_LAT_OUT,
    S_RET_OUT
  } state_e;

  typedef struct packed {
    logic [2:0] func;
    logic [63:0] event_time;
    logic [2:0] event_type;
    logic [63:0] payload;
    logic [5:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [1:0] status;
    logic [63:0] entry_time;
    logic [2:0] entry_type;
    logic [63:0] entry_payload;
    logic [5:0] entry_handle;
    logic [6:0] type_ordinal;
    logic last_of_run;
  } result_t;

  typedef struct packed {
    logic [63:0] etime;
    logic [2:0] etype;
    logic [63:0] data;
    logic [LinkBits-1:0] link;
  } slot_t;
endpackage
`default_nettype wire

// ----- sv/time_ordered_event_queue_top.sv -----
// time ordered event queue: command decode, list walker and slot memory
// Usage: drive a command beat on cmd_i with start_i high while busy_o is low.
// Results leave on result_o, each valid for one cycle with result_valid_o
// high; result_o.last_of_run marks the final result of a command.
// The receiver cannot stall; every result is taken in its cycle.
// Entries sit in one slot memory (time, type, payload, link) with a
// registered synchronous read; the list is walked one slot at a time, each slot read and then checked.
// Insert, execute, retire and first-of-type walk the list from its head
// and stay busy while they walk it. Latest-of-type does not walk; it reads
// the slot named by the latest pointer of its type. A full store, a bad
// handle and an unknown command answer without going busy.
// Each result shows in the cycle after it is formed, so the last result of
// a command can share its cycle with the next start beat.
// Free slot search is a priority encoder over the used bits in flip-flops.
// Reset empties the queue at once: used bits, head and per-type latest
// pointers are cleared; the slot memory itself is not cleared.
// Only one command is in work at a time.
`default_nettype none
module time_ordered_event_queue_top (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire teq_pkg::cmd_t cmd_i,
  output logic busy_o,
  output logic result_valid_o,
  output teq_pkg::result_t result_o
);
  localparam int unsigned LB = teq_pkg::LinkBits;
  localparam int unsigned SB = teq_pkg::SlotBits;

  // slot memory
  teq_pkg::slot_t mem_q [teq_pkg::Capacity];
  logic mem_we;
  logic [SB-1:0] mem_waddr, mem_raddr;
  teq_pkg::slot_t mem_wdata, rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  // control registers
  teq_pkg::state_e state_q, state_d;
  teq_pkg::cmd_t cmd_q, cmd_d;
  logic [teq_pkg::Capacity-1:0] used_q, used_d;
  logic [LB-1:0] head_q, head_d, cur_q, cur_d, prev_q, prev_d;
  logic [LB-1:0] latest_q [teq_pkg::EventTypes];
  logic [LB-1:0] latest_d [teq_pkg::EventTypes];
  logic [SB-1:0] slot_q, slot_d;
  logic [6:0] cnt_q, cnt_d;
  logic [6:0] ord_q [teq_pkg::EventTypes];
  logic [6:0] ord_d [teq_pkg::EventTypes];
  logic pend_q, pend_d;
  teq_pkg::slot_t pend_slot_q, pend_slot_d;
  logic [SB-1:0] pend_addr_q, pend_addr_d;
  logic ltime_gt_q, ltime_gt_d;
  teq_pkg::result_t hold_q, hold_d;
  logic rv_d;
  teq_pkg::result_t res_d;
  logic rv_q;
  teq_pkg::result_t res_q;

  // lowest free slot
  logic [SB-1:0] free_idx;
  logic full;
  always_comb begin
    free_idx = '0;
    full = 1'b1;
    for (int i = teq_pkg::Capacity - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_idx = SB'(i);
        full = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= teq_pkg::S_IDLE;
      used_q <= '0;
      head_q <= teq_pkg::Nil;
      pend_q <= 1'b0;
      rv_q <= 1'b0;
      for (int i = 0; i < teq_pkg::EventTypes; i++) begin
        latest_q[i] <= teq_pkg::Nil;
      end
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      head_q <= head_d;
      pend_q <= pend_d;
      rv_q <= rv_d;
      latest_q <= latest_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cur_q <= cur_d;
    prev_q <= prev_d;
    slot_q <= slot_d;
    cnt_q <= cnt_d;
    ord_q <= ord_d;
    pend_slot_q <= pend_slot_d;
    pend_addr_q <= pend_addr_d;
    ltime_gt_q <= ltime_gt_d;
    hold_q <= hold_d;
    res_q <= res_d;
  end

  assign busy_o = (state_q != teq_pkg::S_IDLE);
  assign result_valid_o = rv_q;
  assign result_o = res_q;

  // result helper
  function automatic teq_pkg::result_t mk(input logic [1:0] kind, input logic [1:0] st,
                                          input logic hit, input teq_pkg::slot_t s,
                                          input logic [SB-1:0] idx, input logic [6:0] ord,
                                          input logic last);
    teq_pkg::result_t r;
    r = '0;
    r.result_kind = kind;
    r.status = st;
    if (hit) begin
      r.entry_time = s.etime;
      r.entry_type = s.etype;
      r.entry_payload = s.data;
      r.entry_handle = idx;
    end
    r.type_ordinal = ord;
    r.last_of_run = last;
    return r;
  endfunction

  // next state and outputs
  always_comb begin
    logic [2:0] ct;
    teq_pkg::slot_t ns;
    ct = '0;
    ns = '0;
    state_d = state_q;
    cmd_d = cmd_q;
    used_d = used_q;
    head_d = head_q;
    cur_d = cur_q;
    prev_d = prev_q;
    latest_d = latest_q;
    slot_d = slot_q;
    cnt_d = cnt_q;
    ord_d = ord_q;
    pend_d = pend_q;
    pend_slot_d = pend_slot_q;
    pend_addr_d = pend_addr_q;
    ltime_gt_d = ltime_gt_q;
    hold_d = hold_q;
    rv_d = 1'b0;
    res_d = res_q;
    mem_we = 1'b0;
    mem_waddr = pend_addr_q;
    mem_wdata = pend_slot_q;
    mem_raddr = cur_q[SB-1:0];

    // a deferred new slot write drains in the cycle after the insert answer is formed, while that answer shows
    case (state_q)
      teq_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          cur_d = head_q;
          prev_d = teq_pkg::Nil;
          cnt_d = '0;
          for (int i = 0; i < teq_pkg::EventTypes; i++) ord_d[i] = '0;
          case (cmd_i.func)
            teq_pkg::FUNC_INSERT: begin
              if (full) begin
                rv_d = 1'b1;
                res_d = mk(teq_pkg::KIND_ACK, teq_pkg::ST_FULL, 1'b0, ns, '0, '0, 1'b1);
              end else begin
                slot_d = free_idx;
                // latest of same type is read first to compare times
                cur_d = latest_q[cmd_i.event_type];
                mem_raddr = latest_q[cmd_i.event_type][SB-1:0];
                state_d = teq_pkg::S_LAT_RD;
                ltime_gt_d = 1'b1;
              end
            end
            teq_pkg::FUNC_EXECUTE: begin
              mem_raddr = head_q[SB-1:0];
              state_d = teq_pkg::S_EXE_RD;
            end
            teq_pkg::FUNC_RETIRE: begin
              if (!used_q[cmd_i.handle]) begin
                rv_d = 1'b1;
                res_d = mk(teq_pkg::KIND_ACK, teq_pkg::ST_BAD_HANDLE, 1'b0, ns, '0, '0,
                           1'b1);
              end else begin
                mem_raddr = cmd_i.handle;
                state_d = teq_pkg::S_RET_RD;
              end
            end
            teq_pkg::FUNC_FIRST: begin
              mem_raddr = head_q[SB-1:0];
              state_d = teq_pkg::S_FIRST_RD;
            end
            teq_pkg::FUNC_LATEST: begin
              cur_d = latest_q[cmd_i.event_type];
              mem_raddr = latest_q[cmd_i.event_type][SB-1:0];
              state_d = teq_pkg::S_LAT_OUT;
            end
            default: begin
              rv_d = 1'b1;
              res_d = mk(teq_pkg::KIND_ACK, teq_pkg::ST_OK, 1'b0, ns, '0, '0, 1'b1);
            end
          endcase
        end
      end

      // insert: latest entry of this type read, decide tracking
      teq_pkg::S_LAT_RD: begin
        ltime_gt_d = (cur_q == teq_pkg::Nil) || (rd_q.etime < cmd_q.event_time);
        cur_d = head_q;
        mem_raddr = head_q[SB-1:0];
        state_d = teq_pkg::S_INS_RD;
      end
      teq_pkg::S_INS_RD: begin
        state_d = teq_pkg::S_INS_CMP;
      end
      teq_pkg::S_INS_CMP: begin
        if (cur_q != teq_pkg::Nil && rd_q.etime <= cmd_q.event_time) begin
          prev_d = cur_q;
          pend_slot_d = rd_q;
          cur_d = rd_q.link;
          mem_raddr = rd_q.link[SB-1:0];
          state_d = teq_pkg::S_INS_RD;
        end else begin
          // link predecessor to the new slot, new slot written next
          if (prev_q == teq_pkg::Nil) begin
            head_d = {1'b0, slot_q};
          end else begin
            ns = pend_slot_q;
            ns.link = {1'b0, slot_q};
            mem_we = 1'b1;
            mem_waddr = prev_q[SB-1:0];
            mem_wdata = ns;
          end
          pend_d = 1'b1;
          pend_addr_d = slot_q;
          pend_slot_d.etime = cmd_q.event_time;
          pend_slot_d.etype = cmd_q.event_type;
          pend_slot_d.data = cmd_q.payload;
          pend_slot_d.link = cur_q;
          used_d[slot_q] = 1'b1;
          if (ltime_gt_q) latest_d[cmd_q.event_type] = {1'b0, slot_q};
          ns.etime = cmd_q.event_time;
          ns.etype = cmd_q.event_type;
          ns.data = cmd_q.payload;
          rv_d = 1'b1;
          res_d = mk(teq_pkg::KIND_ACK, teq_pkg::ST_OK, 1'b1, ns, slot_q, '0, 1'b1);
          state_d = teq_pkg::S_RET_OUT;
        end
      end
      // a spare state writes the new slot
      teq_pkg::S_RET_OUT: begin
        mem_we = pend_q;
        pend_d = 1'b0;
        state_d = teq_pkg::S_IDLE;
      end

      // execute walk
      teq_pkg::S_EXE_RD: begin
        state_d = teq_pkg::S_EXE_CHK;
      end
      teq_pkg::S_EXE_CHK: begin
        if (cur_q != teq_pkg::Nil && rd_q.etime <= cmd_q.event_time &&
            cnt_q < 7'(teq_pkg::MaxOut)) begin
          // show the previous due entry, hold this one until the next check
          if (cnt_q != '0) begin
            rv_d = 1'b1;
            res_d = hold_q;
          end
          ct = rd_q.etype;
          ord_d[ct] = ord_q[ct] + 7'd1;
          cnt_d = cnt_q + 7'd1;
          cur_d = rd_q.link;
          mem_raddr = rd_q.link[SB-1:0];
          hold_d = mk(teq_pkg::KIND_DUE, teq_pkg::ST_OK, 1'b1, rd_q, cur_q[SB-1:0],
                      ord_q[ct] + 7'd1, 1'b0);
          state_d = teq_pkg::S_EXE_RD;
        end else begin
          rv_d = 1'b1;
          state_d = teq_pkg::S_IDLE;
          if (cnt_q == '0) begin
            res_d = mk(teq_pkg::KIND_ACK, teq_pkg::ST_NOT_FOUND, 1'b0, ns, '0, '0, 1'b1);
          end else begin
            // held due entry is the last of the run
            res_d = hold_q;
            res_d.last_of_run = 1'b1;
          end
        end
      end

      // retire: read victim then walk to predecessor
      teq_pkg::S_RET_RD: begin
        state_d = teq_pkg::S_RET_CHK;
        pend_slot_d = '0;
        cur_d = head_q;
        cnt_d = 7'd0;
        mem_raddr = cmd_q.handle;
      end
      teq_pkg::S_RET_CHK: begin
        if (cnt_q == 7'd0) begin
          // victim data captured, start the walk
          slot_d = cmd_q.handle;
          pend_slot_d = rd_q;
          cnt_d = 7'd1;
          mem_raddr = head_q[SB-1:0];
          if (head_q == {1'b0, cmd_q.handle}) begin
            head_d = rd_q.link;
            state_d = teq_pkg::S_IDLE;
            used_d[cmd_q.handle] = 1'b0;
            ct = rd_q.etype;
            if (latest_q[ct] == {1'b0, cmd_q.handle}) latest_d[ct] = teq_pkg::Nil;
            rv_d = 1'b1;
            res_d = mk(teq_pkg::KIND_ACK, teq_pkg::ST_OK, 1'b1, rd_q, cmd_q.handle, '0,
                       1'b1);
          end else begin
            state_d = teq_pkg::S_RET_CHK;
            cnt_d = 7'd2;
          end
        end else if (cnt_q == 7'd2) begin
          cnt_d = 7'd3;
        end else begin
          if (rd_q.link == {1'b0, cmd_q.handle}) begin
            ns = rd_q;
            ns.link = pend_slot_q.link;
            mem_we = 1'b1;
            mem_waddr = cur_q[SB-1:0];
            mem_wdata = ns;
            used_d[cmd_q.handle] = 1'b0;
            ct = pend_slot_q.etype;
            if (latest_q[ct] == {1'b0, cmd_q.handle}) latest_d[ct] = teq_pkg::Nil;
            rv_d = 1'b1;
            res_d = mk(teq_pkg::KIND_ACK, teq_pkg::ST_OK, 1'b1, pend_slot_q, cmd_q.handle,
                       '0, 1'b1);
            state_d = teq_pkg::S_IDLE;
          end else begin
            cur_d = rd_q.link;
            mem_raddr = rd_q.link[SB-1:0];
            cnt_d = 7'd2;
          end
        end
      end

      // first of type walk
      teq_pkg::S_FIRST_RD: begin
        state_d = teq_pkg::S_FIRST_CHK;
      end
      teq_pkg::S_FIRST_CHK: begin
        if (cur_q == teq_pkg::Nil) begin
          rv_d = 1'b1;
          res_d = mk(teq_pkg::KIND_QUERY, teq_pkg::ST_NOT_FOUND, 1'b0, ns, '0, '0, 1'b1);
          state_d = teq_pkg::S_IDLE;
        end else if (rd_q.etype == cmd_q.event_type) begin
          rv_d = 1'b1;
          res_d = mk(teq_pkg::KIND_QUERY, teq_pkg::ST_OK, 1'b1, rd_q, cur_q[SB-1:0], '0,
                     1'b1);
          state_d = teq_pkg::S_IDLE;
        end else begin
          cur_d = rd_q.link;
          mem_raddr = rd_q.link[SB-1:0];
          state_d = teq_pkg::S_FIRST_RD;
        end
      end

      // latest of type answer
      teq_pkg::S_LAT_OUT: begin
        state_d = teq_pkg::S_IDLE;
        rv_d = 1'b1;
        if (cur_q != teq_pkg::Nil && used_q[cur_q[SB-1:0]]) begin
          res_d = mk(teq_pkg::KIND_QUERY, teq_pkg::ST_OK, 1'b1, rd_q, cur_q[SB-1:0], '0,
                     1'b1);
        end else begin
          res_d = mk(teq_pkg::KIND_QUERY, teq_pkg::ST_NOT_FOUND, 1'b0, ns, '0, '0, 1'b1);
        end
      end

      default: state_d = teq_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire
